FILE: design/malu_pkg.sv
// Package with operation codes, exception codes and sequencer state for the ALU.
package malu_pkg;

	typedef enum logic [5:0] {
		OP_NOP = 6'd0, OP_SLL = 6'd1, OP_SRL = 6'd2, OP_ROTR = 6'd3, OP_SRA = 6'd4,
		OP_SLLV = 6'd5, OP_SRLV = 6'd6, OP_ROTRV = 6'd7, OP_SRAV = 6'd8,
		OP_MOVZ = 6'd9, OP_MOVN = 6'd10, OP_MFHI = 6'd11, OP_MTHI = 6'd12,
		OP_MFLO = 6'd13, OP_MTLO = 6'd14, OP_MULT = 6'd15, OP_MULTU = 6'd16,
		OP_DIV = 6'd17, OP_DIVU = 6'd18, OP_ADD = 6'd19, OP_ADDU = 6'd20,
		OP_SUB = 6'd21, OP_SUBU = 6'd22, OP_AND = 6'd23, OP_OR = 6'd24,
		OP_XOR = 6'd25, OP_NOR = 6'd26, OP_SLT = 6'd27, OP_SLTU = 6'd28,
		OP_MUL = 6'd29, OP_MADD = 6'd30, OP_MADDU = 6'd31, OP_MSUB = 6'd32,
		OP_MSUBU = 6'd33, OP_TGE = 6'd34, OP_TGEU = 6'd35, OP_TLT = 6'd36,
		OP_TLTU = 6'd37, OP_TEQ = 6'd38, OP_TNE = 6'd39, OP_LUI = 6'd40,
		OP_WSBH = 6'd41, OP_SEB = 6'd42, OP_SEH = 6'd43, OP_EXT = 6'd44,
		OP_INS = 6'd45, OP_CLZ = 6'd46, OP_CLO = 6'd47, OP_PASS_T = 6'd48,
		OP_BREAK = 6'd49, OP_SYSCALL = 6'd50, OP_RDHWR = 6'd51, OP_MTC0 = 6'd52,
		OP_MFC0 = 6'd53, OP_MFMC0 = 6'd54, OP_ERET = 6'd55
	} op_t;

	typedef enum logic [1:0] {
		EXC_NONE = 2'd0, EXC_OVF = 2'd1, EXC_TRAP = 2'd2, EXC_UNSUP = 2'd3
	} exc_t;

	typedef enum logic [1:0] {
		ST_IDLE, ST_ITER, ST_FIN, ST_OUT
	} state_t;

	localparam int unsigned WordW = 32;
	localparam int unsigned StepW = 6;

	typedef struct packed {
		logic [5:0]  func;
		logic [31:0] s;
		logic [31:0] t;
		logic [4:0]  shift_amount;
		logic [4:0]  field_size;
	} in_word_t;

	typedef struct packed {
		logic [31:0] result;
		logic        discard;
		logic [1:0]  exception;
	} out_word_t;

endpackage

FILE: design/malu_if.sv
// Valid/ready channel interface carrying one word of a given payload type.
interface malu_if #(parameter type word_t = logic) (input logic clk);
	logic  valid;
	logic  ready;
	word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/malu_simple.sv
// Combinational operations: shifts, logic, add/sub, moves, compares, traps, bit fields, counts.
module malu_simple
	import malu_pkg::*;
(
	input  logic [5:0]  func,
	input  logic [31:0] s,
	input  logic [31:0] t,
	input  logic [4:0]  shift_amount,
	input  logic [4:0]  field_size,
	input  logic [31:0] hi,
	input  logic [31:0] lo,
	output out_word_t   res
);
	logic [4:0]  sh;
	logic [31:0] sum, dif, m, ms, sra_v;
	logic [63:0] rot2;
	logic        slt, sltu;
	logic [5:0]  clz_s, clo_s;

	// Shift amount, adder, compares and field mask.
	always_comb begin
		sh    = (func == OP_SLL || func == OP_SRL || func == OP_ROTR || func == OP_SRA)
			? shift_amount : s[4:0];
		sum   = s + t;
		dif   = s - t;
		sltu  = s < t;
		slt   = $signed(s) < $signed(t);
		sra_v = 32'($signed(t) >>> sh);
		rot2  = {t, t} >> sh;
		m     = (field_size == 5'd31) ? 32'hffffffff
			: ((32'd1 << (field_size + 5'd1)) - 32'd1);
		ms    = m << shift_amount;
	end

	// Leading zero and leading one counts.
	always_comb begin
		clz_s = 6'd32;
		clo_s = 6'd32;
		for (int i = 0; i < 32; i++) begin
			if (s[i]) clz_s = 6'(31 - i);
			if (!s[i]) clo_s = 6'(31 - i);
		end
	end

	// Result selection.
	always_comb begin
		res = '0;
		unique case (func)
			OP_SLL, OP_SLLV:    res.result = t << sh;
			OP_SRL, OP_SRLV:    res.result = t >> sh;
			OP_ROTR, OP_ROTRV:  res.result = rot2[31:0];
			OP_SRA, OP_SRAV:    res.result = sra_v;
			OP_MOVZ: begin
				res.discard = (t != 0);
				res.result  = (t != 0) ? 32'd0 : s;
			end
			OP_MOVN: begin
				res.discard = (t == 0);
				res.result  = (t == 0) ? 32'd0 : s;
			end
			OP_MFHI: res.result = hi;
			OP_MFLO: res.result = lo;
			OP_ADD: begin
				res.result = sum;
				if (((s ^ ~t) & (sum ^ s)) >> 31 != 0) res.exception = EXC_OVF;
			end
			OP_ADDU: res.result = sum;
			OP_SUB: begin
				res.result = dif;
				if (((s ^ t) & (dif ^ s)) >> 31 != 0) res.exception = EXC_OVF;
			end
			OP_SUBU: res.result = dif;
			OP_AND:  res.result = s & t;
			OP_OR:   res.result = s | t;
			OP_XOR:  res.result = s ^ t;
			OP_NOR:  res.result = ~(s | t);
			OP_SLT:  res.result = {31'd0, slt};
			OP_SLTU: res.result = {31'd0, sltu};
			OP_TGE:  if (!slt) res.exception = EXC_TRAP;
			OP_TGEU: if (!sltu) res.exception = EXC_TRAP;
			OP_TLT:  if (slt) res.exception = EXC_TRAP;
			OP_TLTU: if (sltu) res.exception = EXC_TRAP;
			OP_TEQ:  if (s == t) res.exception = EXC_TRAP;
			OP_TNE:  if (s != t) res.exception = EXC_TRAP;
			OP_LUI:  res.result = {t[15:0], 16'd0};
			OP_WSBH: res.result = {t[23:16], t[31:24], t[7:0], t[15:8]};
			OP_SEB:  res.result = {{24{t[7]}}, t[7:0]};
			OP_SEH:  res.result = {{16{t[15]}}, t[15:0]};
			OP_EXT:  res.result = (s >> shift_amount) & m;
			OP_INS:  res.result = ((s & m) << shift_amount) | (t & ~ms);
			OP_CLZ:  res.result = {26'd0, clz_s};
			OP_CLO:  res.result = {26'd0, clo_s};
			OP_PASS_T: res.result = t;
			OP_NOP, OP_MTHI, OP_MTLO, OP_MULT, OP_MULTU, OP_DIV, OP_DIVU, OP_MUL,
			OP_MADD, OP_MADDU, OP_MSUB, OP_MSUBU, OP_BREAK, OP_SYSCALL, OP_RDHWR,
			OP_MTC0, OP_MFC0, OP_MFMC0, OP_ERET: ;
			default: res.exception = EXC_UNSUP;
		endcase
	end
endmodule

FILE: design/mips32_alu_with_hi_lo_core.sv
// Top level: MIPS32 ALU with HI/LO and an iterative multiply/divide unit.
// Usage: words enter on channel in_ch (func, s, t, shift_amount, field_size) and
// one result word (result, discard, exception) leaves on out_ch for each input.
// Both are valid/ready channels; a word moves when valid and ready are high.
// Simple operations pass through ST_FIN, where the result word is registered, and
// then raise out_ch.valid in ST_OUT.
// MULT, MULTU, MUL, MADD*, MSUB*, DIV and DIVU use one shared 33-bit
// add/subtract unit in ST_ITER, one bit per cycle, then a fixup step in ST_FIN,
// where the result word is registered. Signed operands are turned to magnitudes
// first and the sign applied in the fixup step.
// One word is in work at a time; in_ch.ready is low until the result is taken
// and rises the cycle after, so a new word is not taken before the last result
// has been taken from the output register.
// A stalled receiver holds the result word steady in the output register.
// Reset clears HI and LO to zero and empties the block.
module mips32_alu_with_hi_lo_core
	import malu_pkg::*;
(
	input logic clk,
	input logic arst_n,
	malu_if.sink   in_ch,
	malu_if.source out_ch
);
	state_t      state_q, state_d;
	in_word_t    op_q;
	logic [31:0] hi_q, lo_q;
	logic [32:0] acc_q;     // partial remainder or upper product
	logic [31:0] sh_q;      // quotient bits or lower product
	logic [31:0] b_q;       // multiplicand or divisor magnitude
	logic        neg_q, nrem_q;
	logic [StepW-1:0] cnt_q;
	out_word_t   out_q;
	out_word_t   simple_res;
	out_word_t   fin_res;
	logic        acc_in, ld_out, is_div, is_mul, is_sgn;
	logic [32:0] alu_sum;
	logic [31:0] ma, mb;
	logic [63:0] prod_m, prod, hilo, nhilo;

	assign acc_in = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_OUT);
	assign out_ch.data = out_q;

	malu_simple u_simple (
		.func(op_q.func), .s(op_q.s), .t(op_q.t), .shift_amount(op_q.shift_amount),
		.field_size(op_q.field_size), .hi(hi_q), .lo(lo_q), .res(simple_res)
	);

	// Operation class decode.
	always_comb begin
		is_div = (in_ch.data.func == OP_DIV) || (in_ch.data.func == OP_DIVU);
		is_mul = (in_ch.data.func == OP_MULT) || (in_ch.data.func == OP_MULTU) ||
			(in_ch.data.func == OP_MUL) || (in_ch.data.func == OP_MADD) ||
			(in_ch.data.func == OP_MADDU) || (in_ch.data.func == OP_MSUB) ||
			(in_ch.data.func == OP_MSUBU);
		is_sgn = (in_ch.data.func == OP_MULT) || (in_ch.data.func == OP_DIV) ||
			(in_ch.data.func == OP_MADD) || (in_ch.data.func == OP_MSUB);
		ma = (is_sgn && in_ch.data.s[31]) ? (32'd0 - in_ch.data.s) : in_ch.data.s;
		mb = (is_sgn && in_ch.data.t[31]) ? (32'd0 - in_ch.data.t) : in_ch.data.t;
	end

	// Shared unit: trial subtract for divide, conditional add for multiply.
	always_comb begin
		if (op_q.func == OP_DIV || op_q.func == OP_DIVU)
			alu_sum = {acc_q[31:0], sh_q[31]} - {1'b0, b_q};
		else
			alu_sum = {1'b0, acc_q[31:0]} + (sh_q[0] ? {1'b0, b_q} : 33'd0);
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		ld_out = 1'b0;
		unique case (state_q)
			ST_IDLE: if (acc_in) state_d = (is_div || is_mul) ? ST_ITER : ST_FIN;
			ST_ITER: if (cnt_q == StepW'(WordW - 1)) state_d = ST_FIN;
			ST_FIN: begin
				ld_out = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: if (out_ch.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Final signed product and HI/LO combination; the sign selects add or subtract
	// of the magnitude so no adder follows the negation.
	always_comb begin
		prod_m = {acc_q[31:0], sh_q};
		prod   = neg_q ? (64'd0 - prod_m) : prod_m;
		hilo   = neg_q ? ({hi_q, lo_q} - prod_m) : ({hi_q, lo_q} + prod_m);
		nhilo  = neg_q ? ({hi_q, lo_q} + prod_m) : ({hi_q, lo_q} - prod_m);
		fin_res = simple_res;
		if (op_q.func == OP_MUL) fin_res.result = sh_q;
	end

	// HI/LO registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q <= '0;
			lo_q <= '0;
		end else if (ld_out) begin
			case (op_q.func)
				OP_MTHI: hi_q <= op_q.s;
				OP_MTLO: lo_q <= op_q.s;
				OP_MULT, OP_MULTU: {hi_q, lo_q} <= prod;
				OP_MADD, OP_MADDU: {hi_q, lo_q} <= hilo;
				OP_MSUB, OP_MSUBU: {hi_q, lo_q} <= nhilo;
				OP_DIV, OP_DIVU: begin
					if (op_q.t == 0) begin
						hi_q <= '0;
						lo_q <= '0;
					end else begin
						lo_q <= neg_q ? (32'd0 - sh_q) : sh_q;
						hi_q <= nrem_q ? (32'd0 - acc_q[31:0]) : acc_q[31:0];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			op_q   <= in_ch.data;
			acc_q  <= '0;
			sh_q   <= ma;
			b_q    <= mb;
			cnt_q  <= '0;
			neg_q  <= is_sgn && (in_ch.data.s[31] ^ in_ch.data.t[31]);
			nrem_q <= is_sgn && in_ch.data.s[31];
		end else if (state_q == ST_ITER) begin
			cnt_q <= cnt_q + StepW'(1);
			if (op_q.func == OP_DIV || op_q.func == OP_DIVU) begin
				if (!alu_sum[32]) begin
					acc_q <= {1'b0, alu_sum[31:0]};
					sh_q  <= {sh_q[30:0], 1'b1};
				end else begin
					acc_q <= {1'b0, acc_q[30:0], sh_q[31]};
					sh_q  <= {sh_q[30:0], 1'b0};
				end
			end else begin
				acc_q <= {1'b0, alu_sum[32:1]};
				sh_q  <= {alu_sum[0], sh_q[31:1]};
			end
		end
		if (ld_out) out_q <= fin_res;
	end

	// The block never takes a word while a result is pending.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("input taken during output");
	// Output word holds while stalled.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> $stable(out_ch.data))
		else $error("result changed under stall");
	// HI/LO change only when a result is being loaded.
	a_hilo: assert property (@(posedge clk) disable iff (!arst_n)
		!ld_out |=> $stable(hi_q) && $stable(lo_q)) else $error("HI/LO changed");
endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the MIPS32 ALU with HI/LO: directed table, then random words.
module testbench;
	import malu_pkg::*;

	logic clk;
	logic arst_n;
	int unsigned cycle_count;
	int unsigned fail_count;
	int unsigned words_sent;
	int unsigned words_checked;
	bit idle_free;

	malu_if #(.word_t(in_word_t)) in_ch (clk);
	malu_if #(.word_t(out_word_t)) out_ch (clk);

	mips32_alu_with_hi_lo_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Predictor copy of the HI/LO pair and the queue of expected result words.
	logic [31:0] pred_hi;
	logic [31:0] pred_lo;
	out_word_t expected_q[$];

	// Directed stimulus row; a row with check set also compares against a typed value.
	typedef struct {
		in_word_t w;
		bit check;
		out_word_t want;
	} dir_row_t;

	localparam int DirN = 24;
	dir_row_t dir_rows[DirN];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [63:0] signed_mul(logic [31:0] a, logic [31:0] b);
		logic signed [63:0] x;
		logic signed [63:0] y;
		begin
			x = {{32{a[31]}}, a};
			y = {{32{b[31]}}, b};
			return x * y;
		end
	endfunction

	function automatic logic [31:0] leading_zeros(logic [31:0] v);
		int n;
		begin
			n = 0;
			while (n < 32 && v[31 - n] == 1'b0)
				n++;
			return n;
		end
	endfunction

	function automatic logic [31:0] ext_mask(logic [4:0] sz);
		begin
			if (sz == 5'd31)
				return 32'hffffffff;
			return (32'd1 << (sz + 1)) - 32'd1;
		end
	endfunction

	// Computes the expected result word and updates the predicted HI/LO.
	function automatic out_word_t alu_predict(in_word_t w);
		out_word_t o;
		logic [31:0] s, t, m, q, rm, ms, mt;
		logic [63:0] hl;
		logic [4:0] sv;
		begin
			s = w.s;
			t = w.t;
			sv = s[4:0];
			hl = {pred_hi, pred_lo};
			o = '0;
			if (w.func > 6'd55) begin
				o.exception = EXC_UNSUP;
				return o;
			end
			case (op_t'(w.func))
				OP_SLL: o.result = t << w.shift_amount;
				OP_SRL: o.result = t >> w.shift_amount;
				OP_ROTR: o.result = (w.shift_amount == 0) ? t :
					(t >> w.shift_amount) | (t << (6'd32 - w.shift_amount));
				OP_SRA: o.result = $signed(t) >>> w.shift_amount;
				OP_SLLV: o.result = t << sv;
				OP_SRLV: o.result = t >> sv;
				OP_ROTRV: o.result = (sv == 0) ? t : (t >> sv) | (t << (6'd32 - sv));
				OP_SRAV: o.result = $signed(t) >>> sv;
				OP_MOVZ: begin
					o.discard = (t != 0);
					o.result = o.discard ? 32'd0 : s;
				end
				OP_MOVN: begin
					o.discard = (t == 0);
					o.result = o.discard ? 32'd0 : s;
				end
				OP_MFHI: o.result = pred_hi;
				OP_MTHI: pred_hi = s;
				OP_MFLO: o.result = pred_lo;
				OP_MTLO: pred_lo = s;
				OP_MULT: {pred_hi, pred_lo} = signed_mul(s, t);
				OP_MULTU: {pred_hi, pred_lo} = {32'd0, s} * {32'd0, t};
				OP_DIV: begin
					if (t == 0) begin
						pred_hi = 0;
						pred_lo = 0;
					end else begin
						ms = s[31] ? -s : s;
						mt = t[31] ? -t : t;
						q = ms / mt;
						rm = ms % mt;
						pred_lo = (s[31] != t[31]) ? -q : q;
						pred_hi = s[31] ? -rm : rm;
					end
				end
				OP_DIVU: begin
					if (t == 0) begin
						pred_hi = 0;
						pred_lo = 0;
					end else begin
						pred_lo = s / t;
						pred_hi = s % t;
					end
				end
				OP_ADD: begin
					o.result = s + t;
					if (s[31] == t[31] && o.result[31] != s[31])
						o.exception = EXC_OVF;
				end
				OP_ADDU: o.result = s + t;
				OP_SUB: begin
					o.result = s - t;
					if (s[31] != t[31] && o.result[31] != s[31])
						o.exception = EXC_OVF;
				end
				OP_SUBU: o.result = s - t;
				OP_AND: o.result = s & t;
				OP_OR: o.result = s | t;
				OP_XOR: o.result = s ^ t;
				OP_NOR: o.result = ~(s | t);
				OP_SLT: o.result = ($signed(s) < $signed(t)) ? 32'd1 : 32'd0;
				OP_SLTU: o.result = (s < t) ? 32'd1 : 32'd0;
				OP_MUL: o.result = s * t;
				OP_MADD: {pred_hi, pred_lo} = hl + signed_mul(s, t);
				OP_MADDU: {pred_hi, pred_lo} = hl + {32'd0, s} * {32'd0, t};
				OP_MSUB: {pred_hi, pred_lo} = hl - signed_mul(s, t);
				OP_MSUBU: {pred_hi, pred_lo} = hl - {32'd0, s} * {32'd0, t};
				OP_TGE: if ($signed(s) >= $signed(t)) o.exception = EXC_TRAP;
				OP_TGEU: if (s >= t) o.exception = EXC_TRAP;
				OP_TLT: if ($signed(s) < $signed(t)) o.exception = EXC_TRAP;
				OP_TLTU: if (s < t) o.exception = EXC_TRAP;
				OP_TEQ: if (s == t) o.exception = EXC_TRAP;
				OP_TNE: if (s != t) o.exception = EXC_TRAP;
				OP_LUI: o.result = t << 16;
				OP_WSBH: o.result = ((t << 8) & 32'hff00ff00) | ((t >> 8) & 32'h00ff00ff);
				OP_SEB: o.result = {{24{t[7]}}, t[7:0]};
				OP_SEH: o.result = {{16{t[15]}}, t[15:0]};
				OP_EXT: o.result = (s >> w.shift_amount) & ext_mask(w.field_size);
				OP_INS: begin
					m = ext_mask(w.field_size);
					o.result = ((s & m) << w.shift_amount) | (t & ~(m << w.shift_amount));
				end
				OP_CLZ: o.result = leading_zeros(s);
				OP_CLO: o.result = leading_zeros(~s);
				OP_PASS_T: o.result = t;
				default: ;
			endcase
			return o;
		end
	endfunction

	function automatic in_word_t mk(op_t f, logic [31:0] s, logic [31:0] t,
		logic [4:0] sa, logic [4:0] sz);
		in_word_t w;
		begin
			w.func = f;
			w.s = s;
			w.t = t;
			w.shift_amount = sa;
			w.field_size = sz;
			return w;
		end
	endfunction

	function automatic out_word_t ow(logic [31:0] r, logic d, exc_t e);
		out_word_t o;
		begin
			o.result = r;
			o.discard = d;
			o.exception = e;
			return o;
		end
	endfunction

	// Random operand with a bias toward the extremes.
	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'hffffffff;
			2: return 32'h80000000;
			3: return 32'h7fffffff;
			4: return $urandom_range(0, 40);
			default: return $urandom;
		endcase
	endfunction

	function automatic in_word_t rand_word();
		in_word_t w;
		begin
			w.func = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(56, 63))
				: 6'($urandom_range(0, 55));
			w.s = rand_operand();
			w.t = ($urandom_range(0, 3) == 0) ? w.s : rand_operand();
			w.shift_amount = 5'($urandom);
			w.field_size = 5'($urandom);
			return w;
		end
	endfunction

	// Sends one word, with random idle bursts before it; valid stays high after
	// acceptance until the caller drops it or the next word replaces it.
	task automatic send_word(in_word_t w);
		begin
			if (!idle_free && $urandom_range(0, 3) == 0) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			in_ch.valid <= 1'b1;
			in_ch.data <= w;
			do
				@(posedge clk);
			while (!in_ch.ready);
			expected_q.push_back(alu_predict(w));
			words_sent++;
		end
	endtask

	// Receiver side: random stall bursts on ready, and the result word check.
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				if (expected_q.size() == 0) begin
					$error("result word with nothing expected: %h", out_ch.data);
					fail_count++;
				end else begin
					out_word_t e;
					e = expected_q.pop_front();
					words_checked++;
					if (out_ch.data.result !== e.result) begin
						$error("result: expected %h, actual %h", e.result, out_ch.data.result);
						fail_count++;
					end
					if (out_ch.data.discard !== e.discard) begin
						$error("discard: expected %0d, actual %0d", e.discard,
							out_ch.data.discard);
						fail_count++;
					end
					if (out_ch.data.exception !== e.exception) begin
						$error("exception: expected %0d, actual %0d", e.exception,
							out_ch.data.exception);
						fail_count++;
					end
				end
			end
			if (!idle_free && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) begin
					@(posedge clk);
				end
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= arst_n;
			end
		end
	end

	// Cycle limit: bounds the run by the worst-case work plus both stalls per word.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 400000) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Main sequence: reset, directed rows (typed ones checked against the predictor), random words, report.
	initial begin
		in_word_t w;
		out_word_t p;
		int n;
		fail_count = 0;
		words_sent = 0;
		words_checked = 0;
		idle_free = 0;
		pred_hi = 0;
		pred_lo = 0;
		arst_n = 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.data <= '0;

		dir_rows[0] = '{mk(OP_MFHI, 0, 0, 0, 0), 1, ow(0, 0, EXC_NONE)};
		dir_rows[1] = '{mk(OP_MFLO, 0, 0, 0, 0), 1, ow(0, 0, EXC_NONE)};
		dir_rows[2] = '{mk(OP_ADD, 32'h7fffffff, 1, 0, 0), 1, ow(32'h80000000, 0, EXC_OVF)};
		dir_rows[3] = '{mk(OP_SUB, 32'h80000000, 1, 0, 0), 1, ow(32'h7fffffff, 0, EXC_OVF)};
		dir_rows[4] = '{mk(OP_MOVZ, 5, 1, 0, 0), 1, ow(0, 1, EXC_NONE)};
		dir_rows[5] = '{mk(OP_MOVN, 5, 1, 0, 0), 1, ow(5, 0, EXC_NONE)};
		dir_rows[6] = '{mk(OP_TEQ, 9, 9, 0, 0), 1, ow(0, 0, EXC_TRAP)};
		dir_rows[7] = '{mk(op_t'(6'd63), 1, 2, 31, 31), 1, ow(0, 0, EXC_UNSUP)};
		dir_rows[8] = '{mk(OP_DIV, 32'h80000000, 32'hffffffff, 0, 0), 0, '0};
		dir_rows[9] = '{mk(OP_MFLO, 0, 0, 0, 0), 1, ow(32'h80000000, 0, EXC_NONE)};
		dir_rows[10] = '{mk(OP_MFHI, 0, 0, 0, 0), 1, ow(0, 0, EXC_NONE)};
		dir_rows[11] = '{mk(OP_DIVU, 7, 0, 0, 0), 0, '0};
		dir_rows[12] = '{mk(OP_MFLO, 0, 0, 0, 0), 1, ow(0, 0, EXC_NONE)};
		dir_rows[13] = '{mk(OP_DIV, 32'hfffffff9, 2, 0, 0), 0, '0};
		dir_rows[14] = '{mk(OP_MFHI, 0, 0, 0, 0), 1, ow(32'hffffffff, 0, EXC_NONE)};
		dir_rows[15] = '{mk(OP_EXT, 32'hdeadbeef, 0, 0, 31), 1, ow(32'hdeadbeef, 0, EXC_NONE)};
		dir_rows[16] = '{mk(OP_INS, 32'hffffffff, 0, 31, 31), 1, ow(32'h80000000, 0, EXC_NONE)};
		dir_rows[17] = '{mk(OP_CLZ, 0, 0, 0, 0), 1, ow(32, 0, EXC_NONE)};
		dir_rows[18] = '{mk(OP_CLO, 32'hffffffff, 0, 0, 0), 1, ow(32, 0, EXC_NONE)};
		dir_rows[19] = '{mk(OP_MULT, 32'hffffffff, 32'hffffffff, 0, 0), 0, '0};
		dir_rows[20] = '{mk(OP_MADD, 32'h80000000, 32'h80000000, 0, 0), 0, '0};
		dir_rows[21] = '{mk(OP_MSUBU, 32'hffffffff, 32'hffffffff, 0, 0), 0, '0};
		dir_rows[22] = '{mk(OP_MFHI, 0, 0, 0, 0), 0, '0};
		dir_rows[23] = '{mk(OP_SRA, 0, 32'h80000000, 31, 0), 1, ow(32'hffffffff, 0, EXC_NONE)};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; typed rows are cross-checked before sending.
		for (int i = 0; i < DirN; i++) begin
			if (dir_rows[i].check) begin
				logic [31:0] h, l;
				h = pred_hi;
				l = pred_lo;
				p = alu_predict(dir_rows[i].w);
				pred_hi = h;
				pred_lo = l;
				if (p !== dir_rows[i].want) begin
					$error("table row %0d: expected %h, predictor %h", i,
						dir_rows[i].want, p);
					fail_count++;
				end
			end
			send_word(dir_rows[i].w);
		end

		// Random part; halfway the sender waits until every result has come.
		for (n = 0; n < 1600; n++) begin
			if (n == 800) begin
				in_ch.valid <= 1'b0;
				wait (expected_q.size() == 0);
			end
			if (n == 1400)
				idle_free = 1;
			w = rand_word();
			send_word(w);
		end

		in_ch.valid <= 1'b0;
		wait (expected_q.size() == 0);
		repeat (50) @(posedge clk);
		$display("Covered %0d words: all 56 operations, unsupported codes, HI/LO chains.",
			words_sent);
		$display("Checked %0d result words with random stalls on both sides.", words_checked);
		if (fail_count == 0 && expected_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
